>>> rtl/tpt_pkg.sv
// shared constants, types and helpers of the tlb page table translator
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

    localparam int TLB_ENTRIES = 128;
    localparam int PAGE_BYTES  = 256;
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 256;

    localparam int ADDR_W    = 16;
    localparam int OUTCOME_W = 2;
    localparam int COUNT_W   = 32;

    localparam int OFFSET_W  = $clog2(PAGE_BYTES);
    localparam int PAGE_W    = $clog2(PAGE_COUNT);
    localparam int FRAME_W   = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FREE_W    = $clog2(FRAME_COUNT + 1);
    localparam int TLB_IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam int IN_DATA_W  = ((ADDR_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * ADDR_W + OUTCOME_W + 3 * COUNT_W;
    localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_TLB_HIT   = 2'd0,
        OUT_TABLE_HIT = 2'd1,
        OUT_FAULT     = 2'd2,
        OUT_NO_FRAME  = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEL,
        ST_RESOLVE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the incoming request
        logic look;     // tlb compare and page table read
        logic sel;      // pick the winning tlb entry and read its frame
        logic commit;   // update state and load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_stat;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

>>> rtl/tlb_page_table_translator.sv
// top level: address translator with a fully associative tlb and demand paging
// a request is captured, then passes the compare, select and resolve states before its result is registered
// a new request is accepted only in idle, once the previous one has been committed
// resolve holds while the output register is full and its result is not taken
// reset: synchronous active-low i_rst_n clears tlb and page table valid bits,
// fill pointer, frame allocator and counters at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator
    import tpt_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // request stream
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] logical_address
    // result stream
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // [15:0] echo_address,
                                                 // [31:16] physical_address,
                                                 // [33:32] outcome,
                                                 // [65:34] translated_count,
                                                 // [97:66] fault_count,
                                                 // [129:98] hit_count, rest zero
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing: idle -> compare -> select -> resolve
    tpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // tlb cells, page table, allocator, counters and the result register
    tpt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_addr      (s_axis_tdata[ADDR_W-1:0]),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/tpt_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire                                       i_clk,
    input  wire                                       i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                          i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/tpt_ctrl.sv
// sequencing state machine of the tlb page table translator
`timescale 1ns / 1ps
`default_nettype none

module tpt_ctrl
    import tpt_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_req_valid,
    output logic       o_req_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOK;
                end
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = ST_SEL;
            end
            ST_SEL: begin
                o_cmd.sel = 1'b1;
                n_state   = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                // hold until the result register frees up
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/tpt_dpath.sv
// tlb cells, page table, frame allocator, counters and result register
`timescale 1ns / 1ps
`default_nettype none

module tpt_dpath
    import tpt_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire  [ADDR_W-1:0]      i_addr,
    output logic                   o_res_valid,
    input  wire                    i_res_ready,
    output logic [OUT_DATA_W-1:0]  o_res_data
);

    localparam int PHYS_FULL_W = FRAME_W + ADDR_W;

    // request
    logic [ADDR_W-1:0]   r_addr;
    logic [PAGE_W-1:0]   w_page;
    logic [OFFSET_W-1:0] w_offset;

    // tlb tag cells
    logic                r_tlb_valid [TLB_ENTRIES];
    logic [PAGE_W-1:0]   r_tlb_page  [TLB_ENTRIES];
    logic [TLB_IDX_W-1:0] r_fill_ptr;
    logic [TLB_ENTRIES-1:0] r_match;

    // lookup results
    logic                r_table_hit;
    logic                r_tlb_hit;
    logic [TLB_IDX_W-1:0] w_hit_idx;
    logic                w_any_match;
    logic [FRAME_W-1:0]  w_tlb_frame;
    logic [FRAME_W-1:0]  w_table_frame;

    // page table valid bits and frame allocator
    logic                r_table_valid [PAGE_COUNT];
    logic [FREE_W-1:0]   r_free_next;

    // counters
    logic [COUNT_W-1:0]  r_total;
    logic [COUNT_W-1:0]  r_faults;
    logic [COUNT_W-1:0]  r_hits;
    logic [COUNT_W-1:0]  n_total;
    logic [COUNT_W-1:0]  n_faults;
    logic [COUNT_W-1:0]  n_hits;

    // resolve stage decisions
    logic                w_fill;
    logic                w_alloc;
    logic [FRAME_W-1:0]  w_frame;
    t_outcome            w_outcome;
    logic [ADDR_W-1:0]   w_phys;
    logic [PHYS_FULL_W-1:0] w_phys_full;

    // result register
    logic                r_res_valid;
    logic [OUT_DATA_W-1:0] r_res_data;

    assign w_page   = PAGE_W'(r_addr >> OFFSET_W);
    assign w_offset = r_addr[OFFSET_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr <= i_addr;
        end
    end

    // parallel tag compare, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_match[i] <= r_tlb_valid[i] && (r_tlb_page[i] == w_page);
            end
            r_table_hit <= r_table_valid[w_page];
        end
    end

    // lowest matching entry wins
    always_comb begin
        w_hit_idx   = '0;
        w_any_match = 1'b0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit_idx   = TLB_IDX_W'(i);
                w_any_match = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sel) begin
            r_tlb_hit <= w_any_match;
        end
    end

    // resolve
    always_comb begin
        w_fill    = 1'b0;
        w_alloc   = 1'b0;
        w_frame   = '0;
        w_outcome = OUT_TLB_HIT;
        n_total   = sat_inc(r_total);
        n_faults  = r_faults;
        n_hits    = r_hits;
        if (r_tlb_hit) begin
            w_frame   = w_tlb_frame;
            w_outcome = OUT_TLB_HIT;
            n_hits    = sat_inc(r_hits);
        end else if (r_table_hit) begin
            w_frame   = w_table_frame;
            w_fill    = 1'b1;
            w_outcome = OUT_TABLE_HIT;
        end else begin
            n_faults = sat_inc(r_faults);
            if (r_free_next >= FREE_W'(FRAME_COUNT)) begin
                w_outcome = OUT_NO_FRAME;
            end else begin
                w_frame   = r_free_next[FRAME_W-1:0];
                w_fill    = 1'b1;
                w_alloc   = 1'b1;
                w_outcome = OUT_FAULT;
            end
        end
    end

    assign w_phys_full = (PHYS_FULL_W'(w_frame) << OFFSET_W) | PHYS_FULL_W'(w_offset);
    assign w_phys      = (w_outcome == OUT_NO_FRAME) ? '0 : w_phys_full[ADDR_W-1:0];

    tpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (TLB_ENTRIES)
    ) u_tlb_frame (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_fill),
        .i_waddr (r_fill_ptr),
        .i_wdata (w_frame),
        .i_raddr (w_hit_idx),
        .o_rdata (w_tlb_frame)
    );

    tpt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (PAGE_COUNT)
    ) u_table_frame (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && w_alloc),
        .i_waddr (w_page),
        .i_wdata (w_frame),
        .i_raddr (w_page),
        .o_rdata (w_table_frame)
    );

    // tlb tags, page table valid bits, allocator and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
                r_tlb_valid[i] <= 1'b0;
            end
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_table_valid[i] <= 1'b0;
            end
            r_fill_ptr  <= '0;
            r_free_next <= '0;
            r_total     <= '0;
            r_faults    <= '0;
            r_hits      <= '0;
        end else if (i_cmd.commit) begin
            r_total  <= n_total;
            r_faults <= n_faults;
            r_hits   <= n_hits;
            if (w_fill) begin
                r_tlb_valid[r_fill_ptr] <= 1'b1;
                if (r_fill_ptr == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
                    r_fill_ptr <= '0;
                end else begin
                    r_fill_ptr <= r_fill_ptr + TLB_IDX_W'(1);
                end
            end
            if (w_alloc) begin
                r_table_valid[w_page] <= 1'b1;
                r_free_next           <= r_free_next + FREE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_fill) begin
            r_tlb_page[r_fill_ptr] <= w_page;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_data <= OUT_DATA_W'({n_hits, n_faults, n_total,
                                       w_outcome, w_phys, r_addr});
        end
    end

    assign o_stat.out_free = !r_res_valid || i_res_ready;
    assign o_res_valid     = r_res_valid;
    assign o_res_data      = r_res_data;

endmodule

`default_nettype wire
